>>> hw/rtl/okrt_pkg.sv
// Package for the ordered keyed record table.
// Holds operation and status codes, the transfer payload structs and sizing constants.
// No dependencies.
package okrt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [KEY_W-1:0]   key;
        logic        [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [KEY_W-1:0]   found_key;
        logic        [VALUE_W-1:0] found_value;
        logic                      last;
    } out_item_t;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins_shift;   // all cells take the record of the neighbor nearer the head
        logic del_hit;     // cells at or behind the hit take the record behind them
    } cell_ctrl_t;

endpackage

>>> hw/rtl/okrt_cell.sv
// One storage cell of the record chain: key, value, compare, and neighbor shifts.
// Depends on okrt_pkg.
module okrt_cell
    import okrt_pkg::*;
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic                      occupied,
    input  logic signed [KEY_W-1:0]   srch_key,
    input  logic                      found_in,
    input  logic signed [KEY_W-1:0]   prev_key,
    input  logic        [VALUE_W-1:0] prev_value,
    input  logic signed [KEY_W-1:0]   next_key,
    input  logic        [VALUE_W-1:0] next_value,
    output logic signed [KEY_W-1:0]   key,
    output logic        [VALUE_W-1:0] value,
    output logic                      match,
    output logic                      found_out
);

    logic signed [KEY_W-1:0]   key_reg;
    logic        [VALUE_W-1:0] value_reg;
    logic                      hit;

    assign hit       = occupied && (key_reg == srch_key);
    assign match     = hit && !found_in;      // first hit from the head
    assign found_out = found_in || hit;
    assign key       = key_reg;
    assign value     = value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_shift)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
        else if (ctrl.del_hit && found_out)
        begin
            key_reg   <= next_key;
            value_reg <= next_value;
        end
    end

endmodule

>>> hw/rtl/ordered_keyed_record_table_top.sv
// Top level of the ordered keyed record table: a chain of okrt_cell plus the
// operation sequencer and the result register. Depends on okrt_pkg and okrt_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_item  (operation, key, value)
//  out     | out_valid / out_ready| out_item (status, found_key, found_value, last)
//
// Insert, lookup and delete finish in the cycle the input transfer happens; all
// cells compare the key at once and shift toward or away from the head together.
// List loads one result per cycle while the result register is free, from a read
// counter, and takes no new input transfer until the last record has been loaded.
// in_ready is high when no list is running and the result register is free or
// being emptied in the same cycle. Reset empties the table (count zero); cell
// contents are left as they are. A stalled out_ready holds the result register.
module ordered_keyed_record_table_top
    import okrt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t                    state_reg, state_next;
    logic      [CNT_W-1:0]     count_reg, count_next;
    logic      [CNT_W-1:0]     list_idx_reg, list_idx_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_item_reg, out_item_next;

    cell_ctrl_t                ctrl;
    logic signed [KEY_W-1:0]   cell_key   [DEPTH];
    logic        [VALUE_W-1:0] cell_value [DEPTH];
    logic                      cell_match [DEPTH];
    logic                      found_chain [DEPTH+1];

    logic                      out_free;
    logic                      in_xfer;
    logic                      is_full;
    logic                      is_empty;
    logic                      any_hit;
    logic signed [KEY_W-1:0]   hit_key;
    logic        [VALUE_W-1:0] hit_value;
    logic                      list_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_xfer   = in_valid && in_ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign any_hit   = found_chain[DEPTH];
    assign list_last = ((list_idx_reg + CNT_W'(1)) == count_reg);

    assign ctrl.ins_shift = in_xfer && (in_item.operation == OP_INSERT) && !is_full;
    assign ctrl.del_hit   = in_xfer && (in_item.operation == OP_DELETE) && any_hit;

    assign found_chain[0] = 1'b0;

    // Record chain: cell 0 is the head.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [KEY_W-1:0]   nk;
        logic        [VALUE_W-1:0] nv;
        logic signed [KEY_W-1:0]   pk;
        logic        [VALUE_W-1:0] pv;
        logic                      occ;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign pk = in_item.key;
            assign pv = in_item.value;
        end
        else
        begin : g_body
            assign pk = cell_key[i-1];
            assign pv = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nk = '0;   // tail slot becomes free after a delete
            assign nv = '0;
        end
        else
        begin : g_inner
            assign nk = cell_key[i+1];
            assign nv = cell_value[i+1];
        end

        okrt_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ),
            .srch_key   (in_item.key),
            .found_in   (found_chain[i]),
            .prev_key   (pk),
            .prev_value (pv),
            .next_key   (nk),
            .next_value (nv),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .match      (cell_match[i]),
            .found_out  (found_chain[i+1])
        );
    end

    // At most one cell flags the first match, so an OR picks its record.
    always_comb
    begin
        hit_key   = '0;
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_match[i])
            begin
                hit_key   = hit_key | cell_key[i];
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        list_idx_next  = list_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.status      = ST_OK;
                    out_item_next.found_key   = '0;
                    out_item_next.found_value = '0;
                    out_item_next.last        = 1'b1;
                    unique case (in_item.operation)
                        OP_INSERT:
                        begin
                            if (is_full)
                                out_item_next.status = ST_FULL;
                            else
                                count_next = count_reg + CNT_W'(1);
                        end
                        OP_LOOKUP:
                        begin
                            if (is_empty)
                                out_item_next.status = ST_EMPTY;
                            else if (!any_hit)
                                out_item_next.status = ST_NOT_FOUND;
                            else
                            begin
                                out_item_next.found_key   = hit_key;
                                out_item_next.found_value = hit_value;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty)
                                out_item_next.status = ST_EMPTY;
                            else if (!any_hit)
                                out_item_next.status = ST_NOT_FOUND;
                            else
                                count_next = count_reg - CNT_W'(1);
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                                out_item_next.status = ST_EMPTY;
                            else
                            begin
                                // records go out from the list state
                                out_valid_next = 1'b0;
                                list_idx_next  = '0;
                                state_next     = S_LIST;
                            end
                        end
                        default:
                        begin
                            out_item_next.status = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.status      = ST_OK;
                    out_item_next.found_key   = cell_key[list_idx_reg[IDX_W-1:0]];
                    out_item_next.found_value = cell_value[list_idx_reg[IDX_W-1:0]];
                    out_item_next.last        = list_last;
                    list_idx_next             = list_idx_reg + CNT_W'(1);
                    if (list_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            list_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_idx_reg  <= list_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> test/testbench.sv
// Self-checking testbench for ordered_keyed_record_table_top.
// Drives insert/lookup/delete/list transfers against a queue-based table predictor.
// Depends on okrt_pkg and the RTL of the table.
module testbench;
    import okrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 240;
    localparam int LONG_HOLD      = 64;     // receiver back-pressure stretch, in cycles
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on either channel

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = ~KEY_MIN;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic        [VALUE_W-1:0] value;
    } record_t;

    // One line of the directed stimulus. A row with reps > 1 repeats the
    // operation with key and value stepped on each transfer.
    typedef struct {
        op_t                       operation;
        logic signed [KEY_W-1:0]   key;
        logic        [VALUE_W-1:0] value;
        int                        reps;
        bit                        typed;      // expected result written out in the row
        status_t                   exp_status;
        logic signed [KEY_W-1:0]   exp_key;
        logic        [VALUE_W-1:0] exp_value;
    } plan_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Predicted contents of the table, newest record at index 0.
    record_t   records[$];
    // Results of the last table_step call, and the ordered list still owed by the DUT.
    out_item_t step_results[$];
    out_item_t expected_results[$];
    plan_row_t plan[$];

    int  errors         = 0;
    int  results_seen   = 0;
    int  ops_seen[4]    = '{0, 0, 0, 0};
    int  full_hits      = 0;
    int  hold_requests  = 0;
    int  idle_count     = 0;
    bit  no_idle        = 1'b0;   // phase without gaps on either side

    ordered_keyed_record_table_top #(.DEPTH(TABLE_DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Table predictor: applies one operation to the record queue and
    // leaves the results it causes in step_results.
    // ------------------------------------------------------------------
    function automatic void table_step(input in_item_t it);
        out_item_t r;
        record_t   rec;
        int        hit;
        step_results.delete();
        r        = '0;
        r.status = ST_OK;
        r.last   = 1'b1;
        // the match nearest the head wins
        hit = -1;
        foreach (records[i])
        begin
            if (hit < 0 && records[i].key == it.key)
                hit = i;
        end
        case (it.operation)
            OP_INSERT:
            begin
                if (records.size() >= TABLE_DEPTH)
                    r.status = ST_FULL;      // record dropped, table unchanged
                else
                begin
                    rec.key   = it.key;
                    rec.value = it.value;
                    records.push_front(rec);
                end
            end
            OP_LOOKUP:
            begin
                if (records.size() == 0)
                    r.status = ST_EMPTY;
                else if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.found_key   = records[hit].key;
                    r.found_value = records[hit].value;
                end
            end
            OP_DELETE:
            begin
                if (records.size() == 0)
                    r.status = ST_EMPTY;
                else if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    records.delete(hit);     // records behind it close the gap
            end
            default:
            begin
                if (records.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    foreach (records[i])
                    begin
                        r.found_key   = records[i].key;
                        r.found_value = records[i].value;
                        r.last        = (i == records.size() - 1);
                        step_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        step_results.push_back(r);
    endfunction

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int idle_cycles();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keys are biased toward ones already stored and a small pool of corner
    // values, so that hits and duplicate keys are common.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && records.size() > 0)
            return records[$urandom_range(0, records.size() - 1)].key;
        if (r < 8)
        begin
            case ($urandom_range(0, 5))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                3:       return -1;
                default: return $urandom_range(1, 4);
            endcase
        end
        return $urandom;
    endfunction

    function automatic void add_row(input op_t operation, input logic signed [KEY_W-1:0] key,
                                    input logic [VALUE_W-1:0] value, input int reps,
                                    input bit typed, input status_t exp_status,
                                    input logic signed [KEY_W-1:0] exp_key,
                                    input logic [VALUE_W-1:0] exp_value);
        plan_row_t row;
        row.operation  = operation;
        row.key        = key;
        row.value      = value;
        row.reps       = reps;
        row.typed      = typed;
        row.exp_status = exp_status;
        row.exp_key    = exp_key;
        row.exp_value  = exp_value;
        plan.push_back(row);
    endfunction

    // Offers one transfer, waits for the handshake, then records what the
    // DUT owes for it. Entered and left just after a falling edge.
    task automatic send_op(input in_item_t it, input bit typed, input out_item_t typed_res);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        table_step(it);
        if (typed)
            expected_results.push_back(typed_res);
        else
        begin
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
        end
        ops_seen[it.operation]++;
        if (it.operation == OP_INSERT && step_results[0].status == ST_FULL)
            full_hits++;
        @(negedge clk);
    endtask

    task automatic send_random(input op_t operation, input logic signed [KEY_W-1:0] key);
        in_item_t it;
        it.operation = operation;
        it.key       = key;
        it.value     = $urandom;
        send_op(it, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // asks for one, so the result register backs up into in_ready.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int holds_done;
        int r;
        holds_done = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!no_idle)
            begin
                r = $urandom_range(0, 99);
                if (r >= 70)
                begin
                    out_ready <= 1'b0;
                    if (r < 95)
                        repeat ($urandom_range(1, 3)) @(negedge clk);
                    else
                        repeat ($urandom_range(8, 40)) @(negedge clk);
                    out_ready <= 1'b1;
                end
                else
                    out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $error("result with nothing expected: status %0d key %0d value %h last %b",
                       out_item.status, out_item.found_key, out_item.found_value,
                       out_item.last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.status !== want.status)
                begin
                    errors++;
                    $error("status: expected %0d, got %0d", want.status, out_item.status);
                end
                if (out_item.found_key !== want.found_key)
                begin
                    errors++;
                    $error("found_key: expected %0d, got %0d",
                           want.found_key, out_item.found_key);
                end
                if (out_item.found_value !== want.found_value)
                begin
                    errors++;
                    $error("found_value: expected %h, got %h",
                           want.found_value, out_item.found_value);
                end
                if (out_item.last !== want.last)
                begin
                    errors++;
                    $error("last: expected %b, got %b", want.last, out_item.last);
                end
            end
        end
    end

    // Watchdog: any stretch this long with no transfer on either side is a hang.
    initial
    begin : watchdog
        wait (rst_n);
        while (idle_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        in_item_t  it;
        out_item_t want;
        int        sent;
        int        phase;
        int        n;
        int        r;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Typed expectations only where the answer is obvious:
        // the empty table, the first two extreme records, misses and the full table.
        add_row(OP_LIST,   '0,      '0,           1, 1, ST_EMPTY,     '0,      '0);
        add_row(OP_LOOKUP, 5,       '0,           1, 1, ST_EMPTY,     '0,      '0);
        add_row(OP_DELETE, 5,       '0,           1, 1, ST_EMPTY,     '0,      '0);
        add_row(OP_INSERT, KEY_MIN, '0,           1, 1, ST_OK,        '0,      '0);
        add_row(OP_INSERT, KEY_MAX, '1,           1, 1, ST_OK,        '0,      '0);
        add_row(OP_LOOKUP, KEY_MIN, '0,           1, 1, ST_OK,        KEY_MIN, '0);
        add_row(OP_LOOKUP, KEY_MAX, '0,           1, 1, ST_OK,        KEY_MAX, '1);
        add_row(OP_LOOKUP, '0,      '0,           1, 1, ST_NOT_FOUND, '0,      '0);
        add_row(OP_DELETE, -1,      '0,           1, 1, ST_NOT_FOUND, '0,      '0);
        // fill to the brim; keys run MAX, MIN, MIN+1, ... so both extremes get twins
        add_row(OP_INSERT, KEY_MAX, 32'h5a5a5a5a, 14, 0, ST_OK,       '0,      '0);
        add_row(OP_INSERT, 7,       '1,           1, 1, ST_FULL,      '0,      '0);
        add_row(OP_LOOKUP, KEY_MAX, '0,           1, 0, ST_OK,        '0,      '0);
        add_row(OP_LIST,   '0,      '0,           1, 0, ST_OK,        '0,      '0);
        add_row(OP_DELETE, KEY_MIN, '0,           1, 0, ST_OK,        '0,      '0);
        add_row(OP_DELETE, KEY_MIN, '0,           1, 0, ST_OK,        '0,      '0);
        add_row(OP_LOOKUP, KEY_MIN, '0,           1, 0, ST_OK,        '0,      '0);
        add_row(OP_LIST,   '0,      '0,           1, 0, ST_OK,        '0,      '0);

        foreach (plan[p])
        begin
            for (n = 0; n < plan[p].reps; n++)
            begin
                it.operation     = plan[p].operation;
                it.key           = plan[p].key + n;
                it.value         = plan[p].value + n * 32'h01000193;
                want             = '0;
                want.status      = plan[p].exp_status;
                want.found_key   = plan[p].exp_key;
                want.found_value = plan[p].exp_value;
                want.last        = 1'b1;
                send_op(it, plan[p].typed, want);
            end
        end

        // Random part, in phases: fill-to-full runs, drain-to-empty runs, and
        // mixed traffic with keys biased toward stored ones.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // two long receiver hold-offs, each with the sender pushing hard
            if (phase == 0 || phase == 12)
            begin
                hold_requests++;
                no_idle = 1'b1;
            end
            else
                no_idle = ($urandom_range(0, 3) == 0);

            r = $urandom_range(0, 9);
            if (phase == 0 || r < 2)
            begin
                while (records.size() < TABLE_DEPTH)
                begin
                    send_random(OP_INSERT, pick_key());
                    sent++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    send_random(OP_INSERT, pick_key());
                    sent++;
                end
                send_random(OP_LIST, $urandom);
                sent++;
            end
            else if (r == 2)
            begin
                while (records.size() > 0)
                begin
                    send_random(OP_DELETE,
                                records[$urandom_range(0, records.size() - 1)].key);
                    sent++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    case ($urandom_range(0, 2))
                        0:       send_random(OP_LOOKUP, pick_key());
                        1:       send_random(OP_DELETE, pick_key());
                        default: send_random(OP_LIST, $urandom);
                    endcase
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(8, 20))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 35)
                        send_random(OP_INSERT, pick_key());
                    else if (r < 60)
                        send_random(OP_LOOKUP, pick_key());
                    else if (r < 85)
                        send_random(OP_DELETE, pick_key());
                    else
                        send_random(OP_LIST, $urandom);
                    sent++;
                end
            end
            phase++;
        end
        in_valid <= 1'b0;

        // let the DUT finish what it owes, then a few quiet cycles
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            $error("%0d expected results never arrived", expected_results.size());
        $display("Ran %0d inserts, %0d lookups, %0d deletes, %0d lists; %0d results checked.",
                 ops_seen[OP_INSERT], ops_seen[OP_LOOKUP], ops_seen[OP_DELETE],
                 ops_seen[OP_LIST], results_seen);
        $display("Table was found full %0d times; %0d mismatches.", full_hits, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/okrt_pkg.sv
hw/rtl/okrt_cell.sv
hw/rtl/ordered_keyed_record_table_top.sv
test/testbench.sv
